// ===== sv/zbpr_pkg.sv =====
// Shared types, constants and helper functions of the point rasterizer.
`timescale 1ns / 1ps
`default_nettype none
package zbpr_pkg;

  localparam int SCREEN_COLS_DEF = 80;
  localparam int SCREEN_ROWS_DEF = 22;
  localparam int FRAC_BITS       = 14;
  localparam int ONE             = 1 << FRAC_BITS;
  localparam int CENTER_COL      = 40;
  localparam int CENTER_ROW      = 12;
  localparam int TOP_SHADE       = 11;

  localparam int COORD_W = 16;
  localparam int CELL_W  = 11;
  localparam int SCALE_W = 8;
  localparam int OOZ_W   = 16;
  localparam int SHADE_W = 4;
  localparam int GLYPH_W = 8;
  localparam int MA_W    = 25;
  localparam int MB_W    = 22;
  localparam int PROD_W  = 48;
  localparam int ROT_W   = 19;
  localparam int SCR_W   = 22;
  localparam int DEN_W   = 18;
  localparam int SD_W    = 20;
  localparam int MH_W    = SCALE_W + OOZ_W;
  localparam int PROJ_SH = OOZ_W + FRAC_BITS;
  localparam int XP_W    = PROD_W - PROJ_SH;
  localparam int MEM_W   = SHADE_W + OOZ_W;
  localparam int IN_W    = 48;
  localparam int OUT_W   = 24;

  localparam logic signed [COORD_W-1:0] ONE_C     = COORD_W'(ONE);
  localparam logic signed [COORD_W-1:0] NEG_ONE_C = -COORD_W'(ONE);
  localparam logic [SHADE_W-1:0]        BLANK_CODE  = 4'd12;
  localparam logic [GLYPH_W-1:0]        BLANK_GLYPH = 8'd32;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_PLOT  = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    FACE_ZP = 3'd0,
    FACE_ZN = 3'd1,
    FACE_XP = 3'd2,
    FACE_XN = 3'd3,
    FACE_YP = 3'd4,
    FACE_YN = 3'd5
  } face_e;

  typedef enum logic [2:0] {
    CFG_COS_PITCH  = 3'd0,
    CFG_SIN_PITCH  = 3'd1,
    CFG_COS_ROLL   = 3'd2,
    CFG_SIN_ROLL   = 3'd3,
    CFG_HORIZ_SCALE = 3'd4,
    CFG_VERT_SCALE = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_PLOT  = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  typedef enum logic [3:0] {
    ST_INIT, ST_IDLE, ST_CLEAR, ST_ROT, ST_DEN, ST_DIV,
    ST_PROJ, ST_FIN, ST_LOOK, ST_CMP, ST_RD_A, ST_RD_B
  } state_e;

  typedef struct packed {
    op_e                        op;
    logic signed [COORD_W-1:0]  x;
    logic signed [COORD_W-1:0]  y;
    logic signed [COORD_W-1:0]  zc;
    logic signed [COORD_W-1:0]  nx;
    logic signed [COORD_W-1:0]  ny;
    logic signed [COORD_W-1:0]  nz;
    logic [CELL_W-1:0]          cell_idx;
  } item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] cos_pitch;
    logic signed [COORD_W-1:0] sin_pitch;
    logic signed [COORD_W-1:0] cos_roll;
    logic signed [COORD_W-1:0] sin_roll;
    logic [SCALE_W-1:0]        horiz_scale;
    logic [SCALE_W-1:0]        vert_scale;
  } cfg_t;

  function automatic logic [GLYPH_W-1:0] shade_glyph(input logic [SHADE_W-1:0] code);
    logic [GLYPH_W-1:0] g;
    case (code)
      4'd0:    g = 8'h2E;
      4'd1:    g = 8'h2C;
      4'd2:    g = 8'h2D;
      4'd3:    g = 8'h7E;
      4'd4:    g = 8'h3A;
      4'd5:    g = 8'h3B;
      4'd6:    g = 8'h3D;
      4'd7:    g = 8'h21;
      4'd8:    g = 8'h2A;
      4'd9:    g = 8'h23;
      4'd10:   g = 8'h24;
      4'd11:   g = 8'h40;
      default: g = BLANK_GLYPH;
    endcase
    return g;
  endfunction

  // level = largest k with 2*(k*ONE)^2 <= sq, capped at the top shade
  function automatic logic [SHADE_W-1:0] shade_level(input logic [PROD_W-1:0] sq);
    logic [SHADE_W-1:0] k;
    logic [PROD_W-1:0]  thr;
    k = '0;
    for (int j = 1; j <= TOP_SHADE; j++) begin
      thr = PROD_W'(2 * j * j) << (2 * FRAC_BITS);
      if (thr <= sq) k = SHADE_W'(j);
    end
    return k;
  endfunction

endpackage
`default_nettype wire

// ===== sv/zbpr_front.sv =====
// Front end: accepts items, decodes face geometry and queues work for the back end.
`timescale 1ns / 1ps
`default_nettype none
module zbpr_front (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      init_busy_i,
  input  wire logic                      s_axis_tvalid,
  output logic                           s_axis_tready,
  input  wire logic [1:0]                s_axis_tuser,  // cmd
  input  wire logic [zbpr_pkg::IN_W-1:0] s_axis_tdata,  // face_sel, surf_u, surf_v, cell_index
  output logic                           q_valid_o,
  output zbpr_pkg::item_t                q_item_o,
  input  wire logic                      q_pop_i
);
  import zbpr_pkg::*;

  logic                      accept, keep, push;
  item_t                     dec;
  logic signed [COORD_W-1:0] u, v;
  item_t                     fifo_q [2];
  logic                      wr_ptr_q, rd_ptr_q;
  logic [1:0]                cnt_q;

  assign u = s_axis_tdata[18:3];
  assign v = s_axis_tdata[34:19];

  always_comb begin
    dec          = '0;
    dec.cell_idx = s_axis_tdata[45:35];
    keep         = 1'b1;
    case (cmd_e'(s_axis_tuser))
      CMD_CLEAR: dec.op = OP_CLEAR;
      CMD_READ:  dec.op = OP_READ;
      CMD_PLOT: begin
        dec.op = OP_PLOT;
        case (face_e'(s_axis_tdata[2:0]))
          FACE_ZP: begin dec.x = u; dec.y = v; dec.zc = ONE_C; dec.nz = ONE_C; end
          FACE_ZN: begin dec.x = u; dec.y = v; dec.zc = NEG_ONE_C; dec.nz = NEG_ONE_C; end
          FACE_XP: begin dec.x = ONE_C; dec.y = u; dec.zc = v; dec.nx = ONE_C; end
          FACE_XN: begin dec.x = NEG_ONE_C; dec.y = u; dec.zc = v; dec.nx = NEG_ONE_C; end
          FACE_YP: begin dec.x = u; dec.y = ONE_C; dec.zc = v; dec.ny = ONE_C; end
          FACE_YN: begin dec.x = u; dec.y = NEG_ONE_C; dec.zc = v; dec.ny = NEG_ONE_C; end
          default: keep = 1'b0;
        endcase
      end
      default: keep = 1'b0;
    endcase
  end

  assign s_axis_tready = (cnt_q != 2'd2) && !init_busy_i;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign push          = accept && keep;
  assign q_valid_o     = (cnt_q != 2'd0);
  assign q_item_o      = fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wr_ptr_q] <= dec;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (q_pop_i) rd_ptr_q <= !rd_ptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(q_pop_i);
    end
  end

endmodule
`default_nettype wire

// ===== sv/zbpr_div.sv =====
// Radix-2 restoring divider for the depth reciprocal, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module zbpr_div (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [zbpr_pkg::DEN_W-1:0]  den_i,
  output logic                             done_o,
  output logic [zbpr_pkg::OOZ_W-1:0]       quo_o
);
  import zbpr_pkg::*;

  logic                 busy_q, done_q;
  logic [3:0]           cnt_q;
  logic [DEN_W-1:0]     rem_q, den_q;
  logic [OOZ_W-1:0]     quo_q;
  logic [DEN_W:0]       r2;
  logic                 ge;

  assign r2 = {rem_q, 1'b0};
  assign ge = r2 >= {1'b0, den_q};

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= den_i;
      rem_q <= DEN_W'(1) << (FRAC_BITS + 16 - OOZ_W);
    end else if (busy_q) begin
      rem_q <= ge ? DEN_W'(r2 - {1'b0, den_q}) : DEN_W'(r2);
      quo_q <= {quo_q[OOZ_W-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 4'd1;
        if (cnt_q == 4'(OOZ_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule
`default_nettype wire

// ===== sv/zbpr_back.sv =====
// Back end: rotation and projection on a shared multiplier, z-test and frame memory.
`timescale 1ns / 1ps
`default_nettype none
module zbpr_back #(
  parameter int SCREEN_COLS = zbpr_pkg::SCREEN_COLS_DEF,
  parameter int SCREEN_ROWS = zbpr_pkg::SCREEN_ROWS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  zbpr_pkg::cfg_t                     cfg_i,
  input  wire logic                          q_valid_i,
  input  zbpr_pkg::item_t                    q_item_i,
  output logic                               q_pop_o,
  output logic                               init_busy_o,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [zbpr_pkg::GLYPH_W-1:0]       out_glyph_o,
  output logic [zbpr_pkg::CELL_W-1:0]        out_index_o
);
  import zbpr_pkg::*;

  localparam int CELL_COUNT = SCREEN_COLS * SCREEN_ROWS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);

  state_e                    st_q, st_d;
  logic [3:0]                cnt_q, cnt_d, cons;
  logic [ADDR_W-1:0]         addr_q;
  item_t                     it_q;
  logic [MEM_W-1:0]          mem [CELL_COUNT];
  logic [MEM_W-1:0]          rdata_q, mem_wd;
  logic                      mem_we, out_load, div_start, div_done;
  logic [OOZ_W-1:0]          div_quo, ooz_q;

  logic signed [MA_W-1:0]        mul_a;
  logic signed [MB_W-1:0]        mul_b;
  logic signed [MA_W+MB_W-1:0]   mul_p;
  logic signed [PROD_W-1:0]      prod_q, acc_q, rsum, xs, ys, xs_adj, ys_adj;
  logic signed [PROD_W-1:0]      xsum_q, ysum_q, sq_q;
  logic signed [ROT_W-1:0]       y1_q, zr_q, ny1_q, nz1_q;
  logic signed [SCR_W-1:0]       bx_q, by_q, nyf_q;
  logic signed [ROT_W:0]         den;
  logic signed [SCR_W:0]         dd;
  logic                          dd_pos;
  logic [OOZ_W-1:0]              dclamp;
  logic [SD_W-1:0]               sd_q;
  logic [MH_W-1:0]               mh_q, mv_q;
  logic [SHADE_W-1:0]            shade_q;
  logic signed [XP_W-1:0]        xp, yp;
  logic                          den_bad, den_small, on_screen, slot_free;
  logic [ADDR_W-1:0]             idx;

  zbpr_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .den_i   (den[DEN_W-1:0]),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (st_q == ST_ROT) begin
      case (cnt_q)
        4'd0:    begin mul_a = MA_W'(it_q.y);  mul_b = MB_W'(cfg_i.cos_pitch); end
        4'd1:    begin mul_a = MA_W'(it_q.zc); mul_b = MB_W'(cfg_i.sin_pitch); end
        4'd2:    begin mul_a = MA_W'(it_q.y);  mul_b = MB_W'(cfg_i.sin_pitch); end
        4'd3:    begin mul_a = MA_W'(it_q.zc); mul_b = MB_W'(cfg_i.cos_pitch); end
        4'd4:    begin mul_a = MA_W'(it_q.x);  mul_b = MB_W'(cfg_i.cos_roll); end
        4'd5:    begin mul_a = MA_W'(y1_q);    mul_b = MB_W'(cfg_i.sin_roll); end
        4'd6:    begin mul_a = MA_W'(it_q.x);  mul_b = MB_W'(cfg_i.sin_roll); end
        4'd7:    begin mul_a = MA_W'(y1_q);    mul_b = MB_W'(cfg_i.cos_roll); end
        4'd8:    begin mul_a = MA_W'(it_q.ny); mul_b = MB_W'(cfg_i.cos_pitch); end
        4'd9:    begin mul_a = MA_W'(it_q.nz); mul_b = MB_W'(cfg_i.sin_pitch); end
        4'd10:   begin mul_a = MA_W'(it_q.ny); mul_b = MB_W'(cfg_i.sin_pitch); end
        4'd11:   begin mul_a = MA_W'(it_q.nz); mul_b = MB_W'(cfg_i.cos_pitch); end
        4'd12:   begin mul_a = MA_W'(it_q.nx); mul_b = MB_W'(cfg_i.sin_roll); end
        4'd13:   begin mul_a = MA_W'(ny1_q);   mul_b = MB_W'(cfg_i.cos_roll); end
        default: ;
      endcase
    end else if (st_q == ST_PROJ) begin
      case (cnt_q)
        4'd0:    begin mul_a = MA_W'(cfg_i.horiz_scale); mul_b = MB_W'(ooz_q); end
        4'd1:    begin mul_a = MA_W'(cfg_i.vert_scale);  mul_b = MB_W'(ooz_q); end
        4'd2:    begin mul_a = MA_W'(mh_q); mul_b = bx_q; end
        4'd3:    begin mul_a = MA_W'(mv_q); mul_b = by_q; end
        4'd4:    begin mul_a = MA_W'(sd_q); mul_b = MB_W'(sd_q); end
        default: ;
      endcase
    end
  end

  assign mul_p = mul_a * mul_b;
  assign cons  = cnt_q - 4'd1;
  // odd steps close a rotated term; pitch Y, roll X and normal Y subtract
  assign rsum  = (cons == 4'd1 || cons == 4'd5 || cons == 4'd9) ? acc_q - prod_q
                                                                : acc_q + prod_q;

  assign den       = (ROT_W+1)'(zr_q) + (ROT_W+1)'(3 * ONE);
  assign den_bad   = den[ROT_W] || (den == '0);
  assign den_small = den <= (ROT_W+1)'(ONE);
  assign dd        = (SCR_W+1)'(nyf_q) - (SCR_W+1)'(nz1_q);
  assign dd_pos    = !dd[SCR_W] && (dd != '0);
  assign dclamp    = (dd > (SCR_W+1)'(65535)) ? '1 : OOZ_W'(dd);

  assign xs     = (PROD_W'(CENTER_COL) <<< PROJ_SH) + xsum_q;
  assign ys     = (PROD_W'(CENTER_ROW) <<< PROJ_SH) + ysum_q;
  assign xs_adj = xs[PROD_W-1] ? xs + PROD_W'((1 << PROJ_SH) - 1) : xs;
  assign ys_adj = ys[PROD_W-1] ? ys + PROD_W'((1 << PROJ_SH) - 1) : ys;
  assign xp     = XP_W'(xs_adj >>> PROJ_SH);
  assign yp     = XP_W'(ys_adj >>> PROJ_SH);
  assign on_screen = !xp[XP_W-1] && (xp < XP_W'(SCREEN_COLS))
                  && !yp[XP_W-1] && (yp < XP_W'(SCREEN_ROWS));
  assign idx    = ADDR_W'(xp) + ADDR_W'(SCREEN_COLS) * ADDR_W'(yp);
  assign slot_free = !out_valid_o || out_ready_i;

  always_comb begin
    st_d      = st_q;
    cnt_d     = cnt_q;
    q_pop_o   = 1'b0;
    div_start = 1'b0;
    mem_we    = 1'b0;
    mem_wd    = {BLANK_CODE, OOZ_W'(0)};
    out_load  = 1'b0;
    case (st_q)
      ST_INIT, ST_CLEAR: begin
        mem_we = 1'b1;
        if (addr_q == ADDR_W'(CELL_COUNT - 1)) st_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          cnt_d   = '0;
          case (q_item_i.op)
            OP_CLEAR: st_d = ST_CLEAR;
            OP_PLOT:  st_d = ST_ROT;
            OP_READ:  st_d = ST_RD_A;
            default:  st_d = ST_IDLE;
          endcase
        end
      end
      ST_ROT: begin
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'd14) st_d = ST_DEN;
      end
      ST_DEN: begin
        cnt_d = '0;
        if (den_bad) st_d = ST_IDLE;
        else if (den_small) st_d = ST_PROJ;
        else begin
          div_start = 1'b1;
          st_d      = ST_DIV;
        end
      end
      ST_DIV: if (div_done) st_d = ST_PROJ;
      ST_PROJ: begin
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'd5) st_d = ST_FIN;
      end
      ST_FIN:  st_d = on_screen ? ST_LOOK : ST_IDLE;
      ST_LOOK: st_d = ST_CMP;
      ST_CMP: begin
        mem_wd = {shade_q, ooz_q};
        mem_we = ooz_q > rdata_q[OOZ_W-1:0];
        st_d   = ST_IDLE;
      end
      ST_RD_A: st_d = ST_RD_B;
      ST_RD_B: begin
        if (slot_free) begin
          out_load = 1'b1;
          st_d     = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_INIT;
      cnt_q       <= '0;
      addr_q      <= '0;
      out_valid_o <= 1'b0;
    end else begin
      st_q  <= st_d;
      cnt_q <= cnt_d;
      case (st_q)
        ST_INIT, ST_CLEAR: addr_q <= addr_q + ADDR_W'(1);
        ST_IDLE: addr_q <= (q_item_i.op == OP_READ) ? ADDR_W'(q_item_i.cell_idx) : '0;
        ST_FIN:  addr_q <= idx;
        default: ;
      endcase
      if (out_load) out_valid_o <= 1'b1;
      else if (out_ready_i) out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[addr_q] <= mem_wd;
    rdata_q <= mem[addr_q];
  end

  always_ff @(posedge clk_i) begin
    prod_q <= PROD_W'(mul_p);
    if (st_q == ST_IDLE) it_q <= q_item_i;
    if (st_q == ST_ROT && cnt_q != 4'd0) begin
      if (!cons[0]) acc_q <= prod_q;
      case (cons)
        4'd1:    y1_q  <= ROT_W'(rsum >>> FRAC_BITS);
        4'd3:    zr_q  <= ROT_W'(rsum >>> FRAC_BITS);
        4'd5:    bx_q  <= SCR_W'(rsum >>> FRAC_BITS);
        4'd7:    by_q  <= SCR_W'(rsum >>> FRAC_BITS);
        4'd9:    ny1_q <= ROT_W'(rsum >>> FRAC_BITS);
        4'd11:   nz1_q <= ROT_W'(rsum >>> FRAC_BITS);
        4'd13:   nyf_q <= SCR_W'(rsum >>> FRAC_BITS);
        default: ;
      endcase
    end
    if (st_q == ST_DEN) begin
      ooz_q <= '1;
      sd_q  <= dd_pos ? SD_W'(dclamp) * SD_W'(11) : '0;
    end
    if (st_q == ST_DIV && div_done) ooz_q <= div_quo;
    if (st_q == ST_PROJ) begin
      case (cnt_q)
        4'd1:    mh_q   <= MH_W'(prod_q);
        4'd2:    mv_q   <= MH_W'(prod_q);
        4'd3:    xsum_q <= prod_q;
        4'd4:    ysum_q <= prod_q;
        4'd5:    sq_q   <= prod_q;
        default: ;
      endcase
    end
    if (st_q == ST_FIN) shade_q <= shade_level(sq_q);
    if (out_load) begin
      out_glyph_o <= (32'(it_q.cell_idx) < CELL_COUNT) ? shade_glyph(rdata_q[MEM_W-1:OOZ_W])
                                                       : BLANK_GLYPH;
      out_index_o <= it_q.cell_idx;
    end
  end

  assign init_busy_o = (st_q == ST_INIT);

endmodule
`default_nettype wire

// ===== sv/zbuffer_point_rasterizer.sv =====
// Top level of the z-buffered point rasterizer onto a character frame.
// Plot: pop, rotation, depth check, divider, projection, screen test, z-test read, write;
// the divider is skipped if the reciprocal saturates; points behind the viewer are dropped.
// Read: the cell goes to the output register once the output slot is free. Clear: every
// cell is swept blank, one cell a cycle. Items run one at a time in the back end; up to two
// queue in front of it. After reset all SCREEN_COLS*SCREEN_ROWS cells (1760 by default) are
// swept blank with s_axis_tready low; registers reset to identity rotation and scales 30/15.
`timescale 1ns / 1ps
`default_nettype none
module zbuffer_point_rasterizer #(
  parameter int SCREEN_COLS = zbpr_pkg::SCREEN_COLS_DEF,
  parameter int SCREEN_ROWS = zbpr_pkg::SCREEN_ROWS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [1:0]                      s_axis_tuser,  // cmd
  input  wire logic [zbpr_pkg::IN_W-1:0]       s_axis_tdata,  // face_sel, surf_u, surf_v, cell_index
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic [zbpr_pkg::OUT_W-1:0]           m_axis_tdata,  // glyph, read_index
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [2:0]                      cfg_index_i,
  input  wire logic [zbpr_pkg::COORD_W-1:0]    cfg_data_i
);
  import zbpr_pkg::*;

  cfg_t                cfg_q;
  logic                q_valid, q_pop, init_busy;
  item_t               q_item;
  logic [GLYPH_W-1:0]  glyph;
  logic [CELL_W-1:0]   read_index;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cos_pitch   <= ONE_C;
      cfg_q.sin_pitch   <= '0;
      cfg_q.cos_roll    <= ONE_C;
      cfg_q.sin_roll    <= '0;
      cfg_q.horiz_scale <= 8'd30;
      cfg_q.vert_scale  <= 8'd15;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_COS_PITCH:   cfg_q.cos_pitch   <= cfg_data_i;
        CFG_SIN_PITCH:   cfg_q.sin_pitch   <= cfg_data_i;
        CFG_COS_ROLL:    cfg_q.cos_roll    <= cfg_data_i;
        CFG_SIN_ROLL:    cfg_q.sin_roll    <= cfg_data_i;
        CFG_HORIZ_SCALE: cfg_q.horiz_scale <= cfg_data_i[SCALE_W-1:0];
        CFG_VERT_SCALE:  cfg_q.vert_scale  <= cfg_data_i[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  zbpr_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .init_busy_i   (init_busy),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .q_valid_o     (q_valid),
    .q_item_o      (q_item),
    .q_pop_i       (q_pop)
  );

  zbpr_back #(
    .SCREEN_COLS (SCREEN_COLS),
    .SCREEN_ROWS (SCREEN_ROWS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .init_busy_o (init_busy),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_glyph_o (glyph),
    .out_index_o (read_index)
  );

  assign m_axis_tdata = {(OUT_W - GLYPH_W - CELL_W)'(0), read_index, glyph};

endmodule
`default_nettype wire

// ===== sv/zbpr_checker.sv =====
// Port-level checker for the point rasterizer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module zbpr_checker #(
  parameter int CELL_COUNT = zbpr_pkg::SCREEN_COLS_DEF * zbpr_pkg::SCREEN_ROWS_DEF
) (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          m_axis_tvalid,
  input wire logic                          m_axis_tready,
  input wire logic [zbpr_pkg::OUT_W-1:0]    m_axis_tdata,
  input wire logic                          cfg_ready_o
);
  import zbpr_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped or changed while stalled");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[OUT_W-1:GLYPH_W+CELL_W] == '0)
    else $error("pad bits of result not zero");

  a_oob_space: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (32'(m_axis_tdata[GLYPH_W+CELL_W-1:GLYPH_W]) >= CELL_COUNT)
      |-> m_axis_tdata[GLYPH_W-1:0] == BLANK_GLYPH)
    else $error("out of range read gave a non-blank glyph");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("config port not ready");

endmodule

bind zbuffer_point_rasterizer zbpr_checker #(
  .CELL_COUNT (SCREEN_COLS * SCREEN_ROWS)
) u_zbpr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .cfg_ready_o   (cfg_ready_o)
);
`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking bench for the z-buffered point rasterizer: directed items, then random plot/read/clear traffic.
`timescale 1ns / 1ps
module testbench;
  import zbpr_pkg::*;

  localparam int CELLS = SCREEN_COLS_DEF * SCREEN_ROWS_DEF;
  localparam longint LIMIT = 3000000;

  typedef struct packed {
    logic [7:0]  glyph;
    logic [10:0] cell_idx;
  } glyph_t;

  class raster_scoreboard;
    bit [3:0]           shade[CELLS];
    bit [15:0]          depth[CELLS];
    logic signed [15:0] cos_p, sin_p, cos_r, sin_r;
    bit [7:0]           hscale, vscale;
    glyph_t             pending[$];
    string              glyphs = ".,-~:;=!*#$@";

    function new();
      cos_p = 16384; sin_p = 0; cos_r = 16384; sin_r = 0;
      hscale = 30; vscale = 15;
      blank_frame();
    endfunction

    function void blank_frame();
      foreach (shade[i]) begin
        shade[i] = 4'd12;
        depth[i] = '0;
      end
    endfunction

    function void write_reg(cfg_idx_e idx, logic [15:0] d);
      case (idx)
        CFG_COS_PITCH:   cos_p = d;
        CFG_SIN_PITCH:   sin_p = d;
        CFG_COS_ROLL:    cos_r = d;
        CFG_SIN_ROLL:    sin_r = d;
        CFG_HORIZ_SCALE: hscale = d[7:0];
        CFG_VERT_SCALE:  vscale = d[7:0];
        default: ;
      endcase
    endfunction

    function longint fshr(longint a);
      return a >>> FRAC_BITS;
    endfunction

    function longint tshr(longint a);
      return (a >= 0) ? (a >>> PROJ_SH) : -((-a) >>> PROJ_SH);
    endfunction

    function void plot_point(logic [2:0] f, longint u, longint v);
      longint one, x, y, zc, nx, ny, nz, cp, sp, cr, sr;
      longint y1, zr, bx, by, ny1, nz1, nyr, den, ooz, xp, yp, d, lhs, thr;
      int idx, k;
      one = ONE; nx = 0; ny = 0; nz = 0;
      cp = cos_p; sp = sin_p; cr = cos_r; sr = sin_r;
      case (f)
        FACE_ZP: begin x = u; y = v; zc = one; nz = one; end
        FACE_ZN: begin x = u; y = v; zc = -one; nz = -one; end
        FACE_XP: begin x = one; y = u; zc = v; nx = one; end
        FACE_XN: begin x = -one; y = u; zc = v; nx = -one; end
        FACE_YP: begin x = u; y = one; zc = v; ny = one; end
        FACE_YN: begin x = u; y = -one; zc = v; ny = -one; end
        default: return;
      endcase
      y1  = fshr(y * cp - zc * sp);
      zr  = fshr(y * sp + zc * cp);
      bx  = fshr(x * cr - y1 * sr);
      by  = fshr(x * sr + y1 * cr);
      ny1 = fshr(ny * cp - nz * sp);
      nz1 = fshr(ny * sp + nz * cp);
      nyr = fshr(nx * sr + ny1 * cr);
      den = zr + 3 * one;
      if (den <= 0) return;
      ooz = (longint'(1) << PROJ_SH) / den;
      if (ooz > 65535) ooz = 65535;
      xp = tshr((longint'(CENTER_COL) << PROJ_SH) + longint'(hscale) * ooz * bx);
      yp = tshr((longint'(CENTER_ROW) << PROJ_SH) + longint'(vscale) * ooz * by);
      if (xp < 0 || xp >= SCREEN_COLS_DEF || yp < 0 || yp >= SCREEN_ROWS_DEF) return;
      idx = int'(xp + SCREEN_COLS_DEF * yp);
      if (ooz <= depth[idx]) return;
      d = nyr - nz1;
      k = 0;
      if (d > 0) begin
        lhs = d * 11;
        lhs = lhs * lhs;
        while (k < TOP_SHADE) begin
          thr = (k + 1) * one;
          if (2 * thr * thr > lhs) break;
          k++;
        end
      end
      depth[idx] = ooz[15:0];
      shade[idx] = k[3:0];
    endfunction

    function void note_input(cmd_e c, logic [2:0] f, logic signed [15:0] u,
                             logic signed [15:0] v, logic [10:0] cell_idx);
      glyph_t g;
      case (c)
        CMD_CLEAR: blank_frame();
        CMD_PLOT:  plot_point(f, longint'(u), longint'(v));
        CMD_READ: begin
          g.glyph    = BLANK_GLYPH;
          g.cell_idx = cell_idx;
          if (cell_idx < CELLS && shade[cell_idx] <= TOP_SHADE)
            g.glyph = glyphs[shade[cell_idx]];
          pending.push_back(g);
        end
        default: ;
      endcase
    endfunction

    function bit check_result(logic [7:0] glyph, logic [10:0] cell_idx, output string msg);
      glyph_t e;
      msg = "";
      if (pending.size() == 0) begin
        $sformat(msg, "unexpected glyph %h for cell %0d", glyph, cell_idx);
        return 0;
      end
      e = pending.pop_front();
      if (glyph !== e.glyph)
        $sformat(msg, "cell %0d: glyph %h, want %h", e.cell_idx, glyph, e.glyph);
      if (cell_idx !== e.cell_idx)
        $sformat(msg, "%s read_index %0d, want %0d", msg, cell_idx, e.cell_idx);
      return msg == "";
    endfunction

    function int lit_cell();
      int start;
      start = $urandom_range(CELLS - 1);
      for (int i = 0; i < CELLS; i++)
        if (shade[(start + i) % CELLS] != 4'd12) return (start + i) % CELLS;
      return start;
    endfunction
  endclass

  logic               clk_i = 0;
  logic               rst_ni = 0;
  logic               s_axis_tvalid = 0;
  logic               s_axis_tready;
  logic [1:0]         s_axis_tuser = '0;
  logic [IN_W-1:0]    s_axis_tdata = '0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 0;
  logic [OUT_W-1:0]   m_axis_tdata;
  logic               cfg_valid_i = 0;
  logic               cfg_ready_o;
  logic [2:0]         cfg_index_i = '0;
  logic [15:0]        cfg_data_i = '0;

  raster_scoreboard sb = new();
  int     errors = 0;
  longint cycles = 0;
  bit     calm = 0;
  int     n_plot = 0, n_read = 0, n_clear = 0, n_cfg = 0, n_seen = 0;

  zbuffer_point_rasterizer dut (.*);

  always begin
    #2 clk_i = 1;
    #2 clk_i = 0;
  end

  task automatic report(string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  always @(posedge clk_i) begin
    string msg;
    cycles++;
    if (cycles > LIMIT) begin
      $display("tb: failure");
      $finish;
    end
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      sb.note_input(cmd_e'(s_axis_tuser), s_axis_tdata[2:0], s_axis_tdata[18:3],
                    s_axis_tdata[34:19], s_axis_tdata[45:35]);
    if (rst_ni && cfg_valid_i && cfg_ready_o)
      sb.write_reg(cfg_idx_e'(cfg_index_i), cfg_data_i);
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      n_seen++;
      if (!sb.check_result(m_axis_tdata[7:0], m_axis_tdata[18:8], msg)) report(msg);
    end
  end

  always @(negedge clk_i)
    m_axis_tready <= calm || ($urandom_range(99) >= 13);

  // called at a falling edge, returns at the next falling edge after acceptance
  task automatic send_item(cmd_e c, logic [2:0] f, logic [15:0] u, logic [15:0] v,
                           logic [10:0] cell_idx);
    int gap;
    if (!calm && $urandom_range(99) < 13) begin
      gap = $urandom_range(1, 6);
      s_axis_tvalid <= 0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser  <= c;
    s_axis_tdata  <= {2'b00, cell_idx, v, u, f};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    case (c)
      CMD_PLOT:  n_plot++;
      CMD_READ:  n_read++;
      CMD_CLEAR: n_clear++;
      default: ;
    endcase
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [15:0] d);
    cfg_valid_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 0;
    n_cfg++;
  endtask

  // up to three clears may still be in flight: one in the back end, two queued
  task automatic drain();
    s_axis_tvalid <= 0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (3 * CELLS + 200) @(negedge clk_i);
  endtask

  task automatic set_view(int cp, int sp, int cr, int sr, int hs, int vs);
    drain();
    write_reg(CFG_COS_PITCH, 16'(cp));
    write_reg(CFG_SIN_PITCH, 16'(sp));
    write_reg(CFG_COS_ROLL, 16'(cr));
    write_reg(CFG_SIN_ROLL, 16'(sr));
    write_reg(CFG_HORIZ_SCALE, 16'(hs));
    write_reg(CFG_VERT_SCALE, 16'(vs));
  endtask

  function automatic logic [15:0] unit_coord();
    return 16'($signed($urandom_range(32768)) - 16384);
  endfunction

  task automatic random_items(int count);
    int done, r;
    done = 0;
    while (done < count) begin
      r = $urandom_range(99);
      if (r < 55) begin
        send_item(CMD_PLOT, 3'($urandom_range(5)), unit_coord(), unit_coord(), 11'($urandom));
        done++;
      end else if (r < 85) begin
        if ($urandom_range(1))
          send_item(CMD_READ, 3'($urandom), 16'($urandom), 16'($urandom), 11'(sb.lit_cell()));
        else
          send_item(CMD_READ, 3'($urandom), 16'($urandom), 16'($urandom), 11'($urandom));
        done++;
      end else if (r < 86) begin
        send_item(CMD_CLEAR, 3'($urandom), 16'($urandom), 16'($urandom), 11'($urandom));
        done++;
      end else if (r < 96) begin
        send_item(CMD_PLOT, 3'($urandom), 16'($urandom), 16'($urandom), 11'($urandom));
      end else begin
        send_item(CMD_NOP, 3'($urandom), 16'($urandom), 16'($urandom), 11'($urandom));
      end
    end
  endtask

  initial begin
    repeat (6) @(negedge clk_i);
    rst_ni <= 1;

    // directed: faces, extremes, blank and out-of-range reads, repeated plots
    send_item(CMD_READ, 3'd0, 16'd0, 16'd0, 11'd0);
    for (int f = 0; f < 6; f++) send_item(CMD_PLOT, 3'(f), 16'd0, 16'd0, 11'd0);
    send_item(CMD_READ, 3'd0, 16'd0, 16'd0, 11'd1000);
    send_item(CMD_PLOT, FACE_ZP, 16'sd16384, -16'sd16384, 11'd0);
    send_item(CMD_PLOT, FACE_ZN, -16'sd16384, 16'sd16384, 11'd0);
    send_item(CMD_PLOT, FACE_XP, 16'h8000, 16'h7FFF, 11'd0);
    send_item(CMD_PLOT, FACE_YN, 16'h7FFF, 16'h8000, 11'd0);
    send_item(CMD_PLOT, FACE_ZP, 16'd0, 16'd0, 11'd0);
    send_item(CMD_PLOT, 3'd6, 16'd0, 16'd0, 11'd0);
    send_item(CMD_PLOT, 3'd7, 16'hFFFF, 16'hFFFF, 11'd0);
    send_item(CMD_NOP, 3'd7, 16'hFFFF, 16'hFFFF, 11'h7FF);
    send_item(CMD_READ, 3'd0, 16'd0, 16'd0, 11'd1000);
    send_item(CMD_READ, 3'd0, 16'd0, 16'd0, 11'd1759);
    send_item(CMD_READ, 3'd0, 16'd0, 16'd0, 11'd1760);
    send_item(CMD_READ, 3'd7, 16'hFFFF, 16'hFFFF, 11'h7FF);
    send_item(CMD_CLEAR, 3'd0, 16'd0, 16'd0, 11'd0);
    send_item(CMD_READ, 3'd0, 16'd0, 16'd0, 11'd1000);

    calm = 1;
    random_items(250);
    calm = 0;
    random_items(80);

    set_view(14189, 8192, 11585, 11585, 30, 15);
    random_items(330);
    set_view(0, 16384, -16384, 0, 255, 255);
    random_items(330);
    set_view(16384, 16384, 16384, 16384, 0, 0);
    send_item(CMD_PLOT, FACE_XP, 16'h8000, 16'h8000, 11'd0);
    random_items(330);
    set_view($urandom_range(32768) - 16384, $urandom_range(32768) - 16384,
             $urandom_range(32768) - 16384, $urandom_range(32768) - 16384,
             $urandom_range(255), $urandom_range(255));
    random_items(330);
    set_view(-16384, 0, -16384, 0, 40, 20);
    random_items(330);

    drain();
    $display("covered %0d plots, %0d reads, %0d clears, %0d register writes",
             n_plot, n_read, n_clear, n_cfg);
    $display("%0d glyphs checked, %0d mismatches, %0d cycles", n_seen, errors, cycles);
    if (errors == 0 && sb.pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
